>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for port-level checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// shared types and constants of the array sort engine
// ----------------------------------------------------------------------------
`default_nettype none

package ase_pkg;

   localparam int KEY_W = 32;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_STORE_CLOSE,
      OP_DROP,
      OP_DROP_CLOSE
   } op_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      op_type                  op;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN_RD,
      BK_SCAN_CMP,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/ase_ram.sv
// ----------------------------------------------------------------------------
// ase_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ase_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ase_front.sv
// ----------------------------------------------------------------------------
// ase_front
// accepts key beats and classifies each as store or drop, open or closing
// ----------------------------------------------------------------------------
`default_nettype none

module ase_front #(
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [ase_pkg::KEY_W-1:0] req_key_value,
   input  wire logic                             req_last_item,
   input  wire logic                             q_full,
   output logic                                  busy,
   output logic                                  push,
   output ase_pkg::item_type                     push_item
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          room;

   assign busy = q_full;
   assign push = start && !q_full;
   assign room = (cnt_ff < CW'(DEPTH));

   always_comb begin
      push_item.key = req_key_value;
      if (room) begin
         push_item.op = req_last_item ? ase_pkg::OP_STORE_CLOSE : ase_pkg::OP_STORE;
      end else begin
         push_item.op = req_last_item ? ase_pkg::OP_DROP_CLOSE : ase_pkg::OP_DROP;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push) begin
         if (req_last_item) begin
            cnt_in = '0;
         end else if (room) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ase_queue.sv
// ----------------------------------------------------------------------------
// ase_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ase_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ase_pkg::item_type push_item,
   input  wire logic              pop,
   output ase_pkg::item_type      head_item,
   output logic                   full,
   output logic                   empty
);

   ase_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ase_back.sv
// ----------------------------------------------------------------------------
// ase_back
// insertion into the sorted key ram and in-order emission of a closed set
// ----------------------------------------------------------------------------
`default_nettype none

module ase_back #(
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ase_pkg::item_type                head_item,
   input  wire logic                             q_empty,
   output logic                                  pop,
   output logic                                  rsp_strobe,
   output logic signed [ase_pkg::KEY_W-1:0]      rsp_sorted_value,
   output logic                                  rsp_last_out,
   output logic                                  rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ase_pkg::back_state_type state_ff;
   ase_pkg::back_state_type state_in;

   logic signed [ase_pkg::KEY_W-1:0] key_ff;
   logic signed [ase_pkg::KEY_W-1:0] key_in;
   logic [AW-1:0]                    pos_ff;
   logic [AW-1:0]                    pos_in;
   logic [AW-1:0]                    emit_ff;
   logic [AW-1:0]                    emit_in;
   logic [CW-1:0]                    fill_ff;
   logic [CW-1:0]                    fill_in;
   logic                             ovf_ff;
   logic                             ovf_in;
   logic                             close_ff;
   logic                             close_in;
   logic                             rdv_ff;
   logic                             rdv_in;
   logic                             rlast_ff;
   logic                             rlast_in;
   logic                             rovf_ff;
   logic                             rovf_in;

   logic                             ram_we;
   logic [AW-1:0]                    ram_waddr;
   logic [ase_pkg::KEY_W-1:0]        ram_wdata;
   logic                             ram_re;
   logic [AW-1:0]                    ram_raddr;
   logic [ase_pkg::KEY_W-1:0]        ram_rdata;

   logic                             key_less;
   logic                             last_issue;
   logic                             head_close;

   assign key_less   = (key_ff < $signed(ram_rdata));
   assign last_issue = ((CW'(emit_ff) + CW'(1)) == fill_ff);
   assign head_close = (head_item.op == ase_pkg::OP_STORE_CLOSE) ||
                       (head_item.op == ase_pkg::OP_DROP_CLOSE);

   ase_ram #(
      .WIDTH (ase_pkg::KEY_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ase_pkg::BK_IDLE: begin
            if (!q_empty) begin
               case (head_item.op)
                  ase_pkg::OP_STORE,
                  ase_pkg::OP_STORE_CLOSE: state_in = ase_pkg::BK_SCAN_RD;
                  ase_pkg::OP_DROP_CLOSE:  state_in = ase_pkg::BK_EMIT;
                  default:                 state_in = ase_pkg::BK_IDLE;
               endcase
            end
         end
         ase_pkg::BK_SCAN_RD: begin
            if (pos_ff == '0) begin
               state_in = close_ff ? ase_pkg::BK_EMIT : ase_pkg::BK_IDLE;
            end else begin
               state_in = ase_pkg::BK_SCAN_CMP;
            end
         end
         ase_pkg::BK_SCAN_CMP: begin
            if (key_less) begin
               state_in = ase_pkg::BK_SCAN_RD;
            end else begin
               state_in = close_ff ? ase_pkg::BK_EMIT : ase_pkg::BK_IDLE;
            end
         end
         ase_pkg::BK_EMIT: begin
            if (last_issue) begin
               state_in = ase_pkg::BK_IDLE;
            end
         end
         default: state_in = ase_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = pos_ff;
      ram_wdata = key_ff;
      ram_re    = 1'b0;
      ram_raddr = pos_ff - AW'(1);
      key_in    = key_ff;
      pos_in    = pos_ff;
      emit_in   = emit_ff;
      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      close_in  = close_ff;
      rdv_in    = 1'b0;
      rlast_in  = 1'b0;
      rovf_in   = rovf_ff;
      case (state_ff)
         ase_pkg::BK_IDLE: begin
            emit_in = '0;
            if (!q_empty) begin
               pop      = 1'b1;
               key_in   = head_item.key;
               pos_in   = fill_ff[AW-1:0];
               close_in = head_close;
               case (head_item.op)
                  ase_pkg::OP_STORE,
                  ase_pkg::OP_STORE_CLOSE: fill_in = fill_ff + CW'(1);
                  default:                 ovf_in  = 1'b1;
               endcase
            end
         end
         ase_pkg::BK_SCAN_RD: begin
            if (pos_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
            end else begin
               ram_re = 1'b1;
            end
         end
         ase_pkg::BK_SCAN_CMP: begin
            ram_we = 1'b1;
            if (key_less) begin
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - AW'(1);
            end
         end
         ase_pkg::BK_EMIT: begin
            ram_re    = 1'b1;
            ram_raddr = emit_ff;
            rdv_in    = 1'b1;
            rlast_in  = last_issue;
            rovf_in   = ovf_ff;
            emit_in   = emit_ff + AW'(1);
            if (last_issue) begin
               fill_in = '0;
               ovf_in  = 1'b0;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      pos_ff   <= pos_in;
      emit_ff  <= emit_in;
      close_ff <= close_in;
      rovf_ff  <= rovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ase_pkg::BK_IDLE;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         rdv_ff   <= 1'b0;
         rlast_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         rdv_ff   <= rdv_in;
         rlast_ff <= rlast_in;
      end
   end

   assign rsp_strobe       = rdv_ff;
   assign rsp_sorted_value = $signed(ram_rdata);
   assign rsp_last_out     = rlast_ff;
   assign rsp_overflow     = rovf_ff;

endmodule

`default_nettype wire

>>> hw/rtl/array_sort_engine.sv
// ----------------------------------------------------------------------------
// array_sort_engine
// collects signed keys and emits each closed set in ascending order
// ----------------------------------------------------------------------------
// A key beat is taken when start is high and busy is low; the beat with
// req_last_item set closes the set. Every key is placed into a sorted ram as
// it arrives: the back end reads the keys above it one by one through the
// single read port of the key ram and shifts each up a slot before it writes
// the new key; a dropped key is only popped and flagged. A two-entry queue
// lets up to two beats be taken while the back end works. Once the closing
// key is in place, the n stored keys come out on back-to-back cycles, one
// per cycle; rsp_strobe marks each and the receiver cannot stall them. Keys
// beyond DEPTH are dropped and rsp_overflow is set on every result of that
// set.
// ----------------------------------------------------------------------------
`default_nettype none

module array_sort_engine #(
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic signed [ase_pkg::KEY_W-1:0] req_key_value,
   input  wire logic                             req_last_item,
   output logic                                  rsp_strobe,
   output logic signed [ase_pkg::KEY_W-1:0]      rsp_sorted_value,
   output logic                                  rsp_last_out,
   output logic                                  rsp_overflow
);

   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;
   ase_pkg::item_type push_item;
   ase_pkg::item_type head_item;

   ase_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_key_value (req_key_value),
      .req_last_item (req_last_item),
      .q_full        (q_full),
      .busy          (busy),
      .push          (push),
      .push_item     (push_item)
   );

   ase_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   ase_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .q_empty          (q_empty),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> hw/rtl/ase_checker.sv
// ----------------------------------------------------------------------------
// ase_checker
// port-level checks on the result stream of the array sort engine
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ase_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_strobe,
   input wire logic signed [ase_pkg::KEY_W-1:0] rsp_sorted_value,
   input wire logic                             rsp_last_out,
   input wire logic                             rsp_overflow
);

   logic mid_set;

   assign mid_set = rsp_strobe && !rsp_last_out;

   // end mark only on a result beat
   `ASSERT_IMPLIES(a_last_on_beat, clock, reset, rsp_last_out, rsp_strobe)

   // a set comes out without gaps
   `ASSERT_NEXT(a_set_contiguous, clock, reset, mid_set, rsp_strobe)

   // keys rise through a set
   `ASSERT_NEXT(a_ascending, clock, reset, mid_set, rsp_sorted_value >= $past(rsp_sorted_value))

   // overflow flag is the same on every beat of a set
   `ASSERT_NEXT(a_overflow_steady, clock, reset, mid_set, rsp_overflow == $past(rsp_overflow))

endmodule

bind array_sort_engine ase_checker u_ase_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_strobe       (rsp_strobe),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_out     (rsp_last_out),
   .rsp_overflow     (rsp_overflow)
);

`default_nettype wire
